// ----- src/wqs_pkg.sv -----
`default_nettype none

package wqs_pkg;

	localparam int MAX_QUEUES  = 64;
	localparam int QUEUE_W     = 6;
	localparam int QCNT_W      = 7;
	localparam int PC_W        = 7;
	localparam int PRIO_W      = 32;
	localparam int TAG_W       = 16;
	localparam int CNT_W       = 32;
	localparam int WHOLE_W     = CNT_W + 1;

	localparam logic [QCNT_W-1:0] QCNT_RESET = 7'd64;
	localparam logic [CNT_W-1:0]  PHI_FRAC   = 32'h9E37_79B9;

	// Remainder unit: eight dividend bits per cycle
	localparam int MOD_STEP_BITS = 8;
	localparam int MOD_STEPS     = (WHOLE_W + MOD_STEP_BITS - 1) / MOD_STEP_BITS;
	localparam int MOD_W         = MOD_STEPS * MOD_STEP_BITS;
	localparam int MOD_STEP_W    = $clog2(MOD_STEPS);

	// Rank search: one byte of the candidate mask per cycle
	localparam int CHUNK_W     = 8;
	localparam int CHUNKS      = MAX_QUEUES / CHUNK_W;
	localparam int CHUNK_IDX_W = $clog2(CHUNKS);
	localparam int CHUNK_BIT_W = $clog2(CHUNK_W);
	localparam int CHUNK_CNT_W = CHUNK_BIT_W + 1;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Classified request handed from front to back
	typedef struct packed {
		logic                  fast;
		logic [QUEUE_W-1:0]    target;
		logic [MAX_QUEUES-1:0] cand;
		logic [PC_W-1:0]       pc;
		logic [PRIO_W-1:0]     prio;
		logic [TAG_W-1:0]      tag;
	} entry_t;

	function automatic logic [PC_W-1:0] popcount64(input logic [MAX_QUEUES-1:0] v);
		logic [PC_W-1:0] c;
		c = '0;
		for (int i = 0; i < MAX_QUEUES; i++) begin
			c = c + PC_W'(v[i]);
		end
		return c;
	endfunction

	function automatic logic [CHUNK_CNT_W-1:0] popcount8(input logic [CHUNK_W-1:0] v);
		logic [CHUNK_CNT_W-1:0] c;
		c = '0;
		for (int i = 0; i < CHUNK_W; i++) begin
			c = c + CHUNK_CNT_W'(v[i]);
		end
		return c;
	endfunction

	function automatic logic [QUEUE_W-1:0] lowest_bit64(input logic [MAX_QUEUES-1:0] v);
		logic [QUEUE_W-1:0] idx;
		idx = '0;
		for (int i = MAX_QUEUES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = QUEUE_W'(i);
			end
		end
		return idx;
	endfunction

	// Position of the set bit of rank r within one byte
	function automatic logic [CHUNK_BIT_W-1:0] pick_in_byte(input logic [CHUNK_W-1:0] b,
		input logic [CHUNK_BIT_W-1:0] r);
		logic [CHUNK_BIT_W-1:0] idx;
		logic [CHUNK_CNT_W-1:0] seen;
		logic                   found;
		idx   = '0;
		seen  = '0;
		found = 1'b0;
		for (int i = 0; i < CHUNK_W; i++) begin
			if (b[i] && !found) begin
				if (seen == {1'b0, r}) begin
					found = 1'b1;
					idx   = CHUNK_BIT_W'(i);
				end else begin
					seen = seen + 1'b1;
				end
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// ----- src/wqs_req_if.sv -----
`default_nettype none

interface wqs_req_if;
	import wqs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [MAX_QUEUES-1:0] affinity_mask;
	logic [MAX_QUEUES-1:0] empty_queue_flags;
	logic [PRIO_W-1:0]     task_priority;
	logic [TAG_W-1:0]      task_tag;

	modport source (output valid, affinity_mask, empty_queue_flags, task_priority, task_tag,
		input ready);
	modport sink (input valid, affinity_mask, empty_queue_flags, task_priority, task_tag,
		output ready);
endinterface

`default_nettype wire

// ----- src/wqs_res_if.sv -----
`default_nettype none

interface wqs_res_if;
	import wqs_pkg::*;

	logic               valid;
	logic               ready;
	logic [QUEUE_W-1:0] target_queue;
	logic               took_empty;
	logic [PRIO_W-1:0]  out_priority;
	logic [TAG_W-1:0]   out_tag;

	modport source (output valid, target_queue, took_empty, out_priority, out_tag,
		input ready);
	modport sink (input valid, target_queue, took_empty, out_priority, out_tag,
		output ready);
endinterface

`default_nettype wire

// ----- src/wqs_fifo.sv -----
`default_nettype none

module wqs_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire wqs_pkg::entry_t  push_data,
	output      logic             full,
	input  wire logic             pop,
	output      wqs_pkg::entry_t  pop_data,
	output      logic             empty
);
	import wqs_pkg::*;

	entry_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full     = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- src/wqs_front.sv -----
`default_nettype none

module wqs_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [wqs_pkg::QCNT_W-1:0] cfg_wr_data,
	wqs_req_if.sink                         req,
	output      logic                       push,
	output      wqs_pkg::entry_t            push_data,
	input  wire logic                       full
);
	import wqs_pkg::*;

	logic [QCNT_W-1:0]     queue_count_q;
	logic [QCNT_W-1:0]     n_live;
	logic [MAX_QUEUES-1:0] live;
	logic [MAX_QUEUES-1:0] empty_live;
	logic [MAX_QUEUES-1:0] aff_live;
	logic [MAX_QUEUES-1:0] cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_count_q <= QCNT_RESET;
		end else if (cfg_wr_en) begin
			queue_count_q <= cfg_wr_data;
		end
	end

	// Clamp the queue count to 1..MAX_QUEUES
	always_comb begin
		if (queue_count_q == '0) begin
			n_live = QCNT_W'(1);
		end else if (queue_count_q > QCNT_W'(MAX_QUEUES)) begin
			n_live = QCNT_W'(MAX_QUEUES);
		end else begin
			n_live = queue_count_q;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_QUEUES; i++) begin
			live[i] = (QCNT_W'(i) < n_live);
		end
	end

	assign empty_live = req.empty_queue_flags & live;
	assign aff_live   = req.affinity_mask & live;
	assign cand       = (aff_live == '0) ? live : aff_live;

	assign req.ready = !full;
	assign push      = req.valid && !full;

	always_comb begin
		push_data.fast   = (empty_live != '0);
		push_data.target = lowest_bit64(empty_live);
		push_data.cand   = cand;
		push_data.pc     = popcount64(cand);
		push_data.prio   = req.task_priority;
		push_data.tag    = req.task_tag;
	end

endmodule

`default_nettype wire

// ----- src/wqs_back.sv -----
`default_nettype none

module wqs_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            empty,
	input  wire wqs_pkg::entry_t head,
	output      logic            pop,
	wqs_res_if.source            res
);
	import wqs_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_SEL  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]             state_q;
	logic [CNT_W-1:0]       counter_q;
	logic [CNT_W-1:0]       snap_q;
	logic [CNT_W-1:0]       prod_hi_q;
	logic [MOD_W-1:0]       dvd_q;
	logic [PC_W-1:0]        rem_q;
	logic [MOD_STEP_W-1:0]  step_q;
	logic [QUEUE_W-1:0]     rank_q;
	logic [CHUNK_IDX_W-1:0] chunk_q;
	logic [MAX_QUEUES-1:0]  cand_q;
	logic [PC_W-1:0]        pc_q;
	logic [PRIO_W-1:0]      prio_hold_q;
	logic [TAG_W-1:0]       tag_hold_q;
	logic [QUEUE_W-1:0]     target_q;

	logic                   out_valid_q;
	logic [QUEUE_W-1:0]     out_target_q;
	logic                   out_fast_q;
	logic [PRIO_W-1:0]      out_prio_q;
	logic [TAG_W-1:0]       out_tag_q;

	logic                   out_free;
	logic                   load_out;
	logic [2*CNT_W-1:0]     prod;
	logic [PC_W-1:0]        rem_next;
	logic [PC_W-1:0]        trial;
	logic [CHUNK_W-1:0]     cur_byte;
	logic [CHUNK_CNT_W-1:0] byte_cnt;
	logic                   hit;

	assign out_free = !out_valid_q || res.ready;
	assign pop      = (state_q == ST_IDLE) && !empty && (!head.fast || out_free);
	assign load_out = ((state_q == ST_IDLE) && pop && head.fast) ||
		((state_q == ST_DONE) && out_free);
	assign prod     = {{CNT_W{1'b0}}, snap_q} * {{CNT_W{1'b0}}, PHI_FRAC};

	// Eight restoring steps of the remainder per cycle
	always_comb begin
		rem_next = rem_q;
		trial    = '0;
		for (int i = 0; i < MOD_STEP_BITS; i++) begin
			trial = {rem_next[PC_W-2:0], dvd_q[MOD_W-1-i]};
			if (trial >= pc_q) begin
				rem_next = trial - pc_q;
			end else begin
				rem_next = trial;
			end
		end
	end

	assign cur_byte = cand_q[CHUNK_W-1:0];
	assign byte_cnt = popcount8(cur_byte);
	assign hit      = ({1'b0, rank_q} < (QUEUE_W + 1)'(byte_cnt));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			counter_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && !head.fast) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					counter_q <= counter_q + 1'b1;
					state_q   <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == MOD_STEP_W'(MOD_STEPS - 1)) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (hit) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					if (head.fast) begin
						out_target_q <= head.target;
						out_fast_q   <= 1'b1;
						out_prio_q   <= head.prio;
						out_tag_q    <= head.tag;
					end else begin
						snap_q      <= counter_q;
						cand_q      <= head.cand;
						pc_q        <= head.pc;
						prio_hold_q <= head.prio;
						tag_hold_q  <= head.tag;
					end
				end
			end
			ST_MUL: begin
				prod_hi_q <= prod[2*CNT_W-1:CNT_W];
			end
			ST_ADD: begin
				dvd_q  <= MOD_W'({1'b0, snap_q} + {1'b0, prod_hi_q});
				rem_q  <= '0;
				step_q <= '0;
			end
			ST_DIV: begin
				rem_q   <= rem_next;
				dvd_q   <= dvd_q << MOD_STEP_BITS;
				step_q  <= step_q + 1'b1;
				rank_q  <= rem_next[QUEUE_W-1:0];
				chunk_q <= '0;
			end
			ST_SEL: begin
				if (hit) begin
					target_q <= {chunk_q, pick_in_byte(cur_byte, rank_q[CHUNK_BIT_W-1:0])};
				end else begin
					rank_q  <= rank_q - QUEUE_W'(byte_cnt);
					cand_q  <= cand_q >> CHUNK_W;
					chunk_q <= chunk_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_target_q <= target_q;
					out_fast_q   <= 1'b0;
					out_prio_q   <= prio_hold_q;
					out_tag_q    <= tag_hold_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid        = out_valid_q;
	assign res.target_queue = out_target_q;
	assign res.took_empty   = out_fast_q;
	assign res.out_priority = out_prio_q;
	assign res.out_tag      = out_tag_q;

	a_counter_only_spread: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_MUL) |=> $stable(counter_q))
		else $error("spread counter moved outside the spread path");

	a_rem_below_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < pc_q))
		else $error("remainder not below the candidate count");

	a_rank_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEL) |-> ({1'b0, rank_q} < popcount64(cand_q)))
		else $error("rank beyond the remaining candidates");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished spread result not delivered");

endmodule

`default_nettype wire

// ----- src/work_queue_selector.sv -----
// Work queue selector: places each task request on one of up to 64 work queues. A request is
// accepted whenever the two-entry queue between the classifying front and the placing back has
// room, so the input side keeps moving while a result waits on the output register. If any
// active queue is empty, the lowest such queue is taken (took_empty = 1) and the request passes
// through the two-entry queue to the output register. Otherwise the affinity mask, cut to the
// active queues (or all active queues if nothing is left), is spread over by a golden-ratio
// sequence: the 32x32 product, then the add, then the remainder unit (eight dividend bits a
// cycle) and last the byte-wise rank search, all in the back, which handles one request at a
// time. queue_count is written through cfg_wr_en / cfg_wr_data and must only change while no
// request is in flight.
`default_nettype none

module work_queue_selector (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [wqs_pkg::QCNT_W-1:0] cfg_wr_data,
	wqs_req_if.sink                         req,
	wqs_res_if.source                       res
);
	import wqs_pkg::*;

	// Classified requests between front and back
	entry_t push_data;
	entry_t head;
	logic   push;
	logic   full;
	logic   pop;
	logic   empty;

	// Front: hold the queue count, classify each request and push it
	wqs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.push        (push),
		.push_data   (push_data),
		.full        (full)
	);

	// Decouple the two halves so each can stall on its own
	wqs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (empty)
	);

	// Back: advance the spread counter, reduce and pick the target, drive the result
	wqs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.res    (res)
	);

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the work queue selector.
// A sender process offers task requests on req_ch and a receiver process takes placements
// from res_ch.
// Each accepted request is run through a local placement model. The model's outcome joins a
// queue of pending placements, and each placement that leaves the block is compared with the
// oldest entry of that queue.
module testbench;
	import wqs_pkg::*;

	// Golden-ratio fraction, 32 fraction bits, truncated
	localparam logic [31:0] PHI_FRACTION = 32'h9E37_79B9;

	localparam logic [63:0] ALL_Q = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] TOP_Q = 64'h8000_0000_0000_0000;

	localparam logic [7:0] KEEP_COUNT   = 8'hFF; // leave queue_count as it is
	localparam int         RANDOM_COUNT = -1;    // draw queue_count at random

	localparam int MAX_GAP        = 11;
	localparam int LONG_HOLD      = 80;   // receiver hold-off to back the block up
	localparam int LONG_HOLD_AT   = 150;  // placement count at which that hold starts
	localparam int ITEMS_PER_PASS = 48;
	localparam int SETTLE_CYCLES  = 24;
	localparam int STALL_LIMIT    = 4000; // cycles with no handshake on either side

	typedef struct packed {
		logic [MAX_QUEUES-1:0] aff;
		logic [MAX_QUEUES-1:0] empty;
		logic [PRIO_W-1:0]     prio;
		logic [TAG_W-1:0]      tag;
	} request_t;

	typedef struct packed {
		logic [QUEUE_W-1:0] target;
		logic               fast;
		logic [PRIO_W-1:0]  prio;
		logic [TAG_W-1:0]   tag;
	} placement_t;

	typedef struct packed {
		logic [7:0]            qc;       // queue_count to set first, or KEEP_COUNT
		logic [MAX_QUEUES-1:0] aff;
		logic [MAX_QUEUES-1:0] empty;
		logic [PRIO_W-1:0]     prio;
		logic [TAG_W-1:0]      tag;
		logic                  typed;    // expected target and path given in the row
		logic [QUEUE_W-1:0]    t_target;
		logic                  t_fast;
	} stim_row_t;

	// Directed table. Rows with typed = 1 carry an outcome that is plain to see; the rest
	// rely on the placement model.
	localparam int N_ROWS = 21;
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		// straight after reset: counter zero, so rank zero of all queues
		'{KEEP_COUNT, 64'd0, 64'd0, 32'd0, 16'd0, 1'b1, 6'd0, 1'b0},
		// only the top queue empty
		'{KEEP_COUNT, ALL_Q, TOP_Q, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 6'd63, 1'b1},
		// every queue empty: lowest wins
		'{KEEP_COUNT, 64'd0, ALL_Q, 32'h8000_0000, 16'h8000, 1'b1, 6'd0, 1'b1},
		// single allowed queue on the spread path
		'{KEEP_COUNT, TOP_Q, 64'd0, 32'd1, 16'd1, 1'b1, 6'd63, 1'b0},
		'{KEEP_COUNT, ALL_Q, 64'd0, 32'h1234_5678, 16'h0001, 1'b0, 6'd0, 1'b0},
		// two empty queues in the middle
		'{KEEP_COUNT, 64'd0, 64'h0000_0300_0000_0000, 32'hDEAD_BEEF, 16'h0F0F, 1'b1, 6'd40, 1'b1},
		'{KEEP_COUNT, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0, 32'h5555_5555, 16'hAAAA, 1'b0, 6'd0, 1'b0},
		'{KEEP_COUNT, 64'h5555_5555_5555_5555, 64'd0, 32'hAAAA_AAAA, 16'h5555, 1'b0, 6'd0, 1'b0},
		'{KEEP_COUNT, 64'h8000_0000_0000_0001, 64'd0, 32'h0000_FFFF, 16'h00FF, 1'b0, 6'd0, 1'b0},
		'{KEEP_COUNT, 64'hFFFF_FFFF_0000_0000, 64'd0, 32'hFFFF_0000, 16'hFF00, 1'b0, 6'd0, 1'b0},
		'{KEEP_COUNT, 64'h0000_0000_FFFF_FFFF, 64'd0, 32'h7FFF_FFFF, 16'h7FFF, 1'b0, 6'd0, 1'b0},
		// one queue: empty flags above it are ignored, spread lands on queue 0
		'{8'd1, ALL_Q, 64'hFFFF_FFFF_FFFF_FFFE, 32'd2, 16'd2, 1'b1, 6'd0, 1'b0},
		'{KEEP_COUNT, 64'd0, 64'd1, 32'd3, 16'd3, 1'b1, 6'd0, 1'b1},
		// zero queues behaves as one; affinity outside falls back to all active queues
		'{8'd0, 64'd2, 64'd0, 32'd4, 16'd4, 1'b1, 6'd0, 1'b0},
		// count above the maximum saturates to all queues
		'{8'd127, 64'd0, TOP_Q, 32'd5, 16'd5, 1'b1, 6'd63, 1'b1},
		'{KEEP_COUNT, ALL_Q, 64'd0, 32'd6, 16'd6, 1'b0, 6'd0, 1'b0},
		// two queues: affinity only outside, then empty flags only outside
		'{8'd2, 64'h20, 64'd0, 32'd7, 16'd7, 1'b0, 6'd0, 1'b0},
		'{KEEP_COUNT, 64'h3, 64'hFFFF_FFFF_FFFF_FFFC, 32'd8, 16'd8, 1'b0, 6'd0, 1'b0},
		'{8'd64, 64'd1, 64'd0, 32'd9, 16'd9, 1'b1, 6'd0, 1'b0},
		// 33 queues: highest active queue empty, then only the first inactive one
		'{8'd33, ALL_Q, 64'h0000_0001_0000_0000, 32'd10, 16'd10, 1'b1, 6'd32, 1'b1},
		'{KEEP_COUNT, ALL_Q, 64'h0000_0002_0000_0000, 32'd11, 16'd11, 1'b0, 6'd0, 1'b0}
	};

	// One queue_count per random pass
	localparam int PASS_COUNTS [10] = '{64, 1, 17, 2, 0, 127, 63, 8, 40, RANDOM_COUNT};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [QCNT_W-1:0]    cfg_wr_data;

	wqs_req_if req_ch ();
	wqs_res_if res_ch ();

	work_queue_selector uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.res         (res_ch)
	);

	// Model state: its own copy of the register and of the spread counter
	logic [QCNT_W-1:0] queue_limit;
	logic [CNT_W-1:0]  kronecker_idx;

	placement_t pending_placements [$];

	int  errors;
	int  placements_seen;
	int  n_fast;
	int  n_spread;
	int  n_settings;
	bit  burst;      // no idling on either side while set

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [QUEUE_W-1:0] lowest_queue(input logic [MAX_QUEUES-1:0] v);
		logic [QUEUE_W-1:0] idx;
		idx = '0;
		for (int i = MAX_QUEUES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = QUEUE_W'(i);
			end
		end
		return idx;
	endfunction

	// Work out where one request goes and advance the spread counter on the spread path
	function automatic placement_t place_task(input request_t r);
		placement_t            p;
		logic [MAX_QUEUES-1:0] live;
		logic [MAX_QUEUES-1:0] idle_q;
		logic [MAX_QUEUES-1:0] cand;
		logic [63:0]           c;
		logic [63:0]           whole;
		int                    n;
		int                    rank;
		n = int'(queue_limit);
		if (n == 0) begin
			n = 1;
		end
		if (n > MAX_QUEUES) begin
			n = MAX_QUEUES;
		end
		live   = (n >= 64) ? ALL_Q : ((64'd1 << n) - 64'd1);
		idle_q = r.empty & live;
		p.prio = r.prio;
		p.tag  = r.tag;
		if (idle_q != '0) begin
			p.target = lowest_queue(idle_q);
			p.fast   = 1'b1;
			n_fast++;
		end else begin
			cand = r.aff & live;
			if (cand == '0) begin
				cand = live;
			end
			// integer part of counter * (1 + fraction / 2^32)
			c     = {32'd0, kronecker_idx};
			whole = c + ((c * {32'd0, PHI_FRACTION}) >> 32);
			rank  = int'(whole % 64'($countones(cand)));
			for (int k = 0; k < rank; k++) begin
				cand = cand & (cand - 64'd1);
			end
			p.target      = lowest_queue(cand);
			p.fast        = 1'b0;
			kronecker_idx = kronecker_idx + 32'd1;
			n_spread++;
		end
		return p;
	endfunction

	function automatic request_t random_request();
		request_t r;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: r.empty = '0;
			4, 5:       r.empty = 64'd1 << $urandom_range(0, 63);
			6:          r.empty = {$urandom & $urandom & $urandom, $urandom & $urandom & $urandom};
			7, 8:       r.empty = {$urandom, $urandom};
			default:    r.empty = ALL_Q;
		endcase
		case ($urandom_range(0, 9))
			0:          r.aff = '0;
			1:          r.aff = ALL_Q;
			2:          r.aff = 64'd1 << $urandom_range(0, 63);
			3, 4, 5:    r.aff = {$urandom, $urandom};
			6, 7:       r.aff = {$urandom & $urandom, $urandom & $urandom};
			default:    r.aff = {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
		r.prio = $urandom;
		r.tag  = TAG_W'($urandom_range(0, 65535));
		return r;
	endfunction

	// Offer one request after a random gap, or none while burst is set, and log its placement once it is taken.
	// Valid stays high across back-to-back requests so it never toggles within one step.
	task automatic offer(input request_t r, input logic typed, input logic [QUEUE_W-1:0] t_target,
		input logic t_fast);
		placement_t p;
		int         gap;
		gap = burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid             <= 1'b1;
		req_ch.affinity_mask     <= r.aff;
		req_ch.empty_queue_flags <= r.empty;
		req_ch.task_priority     <= r.prio;
		req_ch.task_tag          <= r.tag;
		do @(posedge clk); while (!req_ch.ready);
		p = place_task(r);
		// rows with a typed outcome override the model, but the model still steps
		if (typed) begin
			p.target = t_target;
			p.fast   = t_fast;
		end
		pending_placements.push_back(p);
	endtask

	// Drop valid, wait until every placement is out, then write queue_count
	task automatic set_queue_count(input logic [QCNT_W-1:0] v);
		req_ch.valid <= 1'b0;
		while (pending_placements.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		queue_limit = v;
		n_settings++;
	endtask

	// Hold every input at a known value from time zero
	initial begin
		arst_n                   = 1'b0;
		cfg_wr_en                = 1'b0;
		cfg_wr_data              = '0;
		req_ch.valid             = 1'b0;
		req_ch.affinity_mask     = '0;
		req_ch.empty_queue_flags = '0;
		req_ch.task_priority     = '0;
		req_ch.task_tag          = '0;
		res_ch.ready             = 1'b0;
		queue_limit              = QCNT_W'(64);
		kronecker_idx            = '0;
		errors                   = 0;
		placements_seen          = 0;
		n_fast                   = 0;
		n_spread                 = 0;
		n_settings               = 0;
		burst                    = 1'b0;
	end

	// Main sequence: reset, directed table, random passes, drain, verdict
	initial begin
		request_t r;
		int       qc;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows, starting on the reset value of queue_count
		for (int i = 0; i < N_ROWS; i++) begin
			if (DIRECTED[i].qc != KEEP_COUNT) begin
				set_queue_count(QCNT_W'(DIRECTED[i].qc));
			end
			r.aff   = DIRECTED[i].aff;
			r.empty = DIRECTED[i].empty;
			r.prio  = DIRECTED[i].prio;
			r.tag   = DIRECTED[i].tag;
			offer(r, DIRECTED[i].typed, DIRECTED[i].t_target, DIRECTED[i].t_fast);
		end

		// Random passes, one queue_count each; every fourth pass runs without idling.
		// Each write also makes the sender pause until the block has drained.
		for (int p = 0; p < 10; p++) begin
			qc = PASS_COUNTS[p];
			if (qc == RANDOM_COUNT) begin
				qc = $urandom_range(1, MAX_QUEUES);
			end
			set_queue_count(QCNT_W'(qc));
			burst = (p % 4 == 3);
			for (int i = 0; i < ITEMS_PER_PASS; i++) begin
				offer(random_request(), 1'b0, '0, 1'b0);
			end
		end
		burst = 1'b0;

		// Drain, then let the block settle before the verdict
		req_ch.valid <= 1'b0;
		while (pending_placements.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Placed %0d requests: %0d to an empty queue, %0d by golden-ratio spread,",
			placements_seen, n_fast, n_spread);
		$display("over %0d queue_count settings including 0, 1, 64 and 127.", n_settings);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Receiver: random hold-off per placement, one long hold to back the block up,
	// and a field-by-field check against the oldest pending placement
	initial begin
		placement_t exp_p;
		int         hold;
		wait (arst_n);
		forever begin
			hold = burst ? 0 : $urandom_range(0, MAX_GAP);
			if (placements_seen == LONG_HOLD_AT) begin
				hold = LONG_HOLD;
			end
			if (hold != 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			placements_seen++;
			if (pending_placements.size() == 0) begin
				$error("placement with no request pending: queue %0d, tag %0h",
					res_ch.target_queue, res_ch.out_tag);
				errors++;
			end else begin
				exp_p = pending_placements.pop_front();
				if (res_ch.target_queue !== exp_p.target) begin
					$error("target_queue: expected %0d, got %0d", exp_p.target,
						res_ch.target_queue);
					errors++;
				end
				if (res_ch.took_empty !== exp_p.fast) begin
					$error("took_empty: expected %0d, got %0d", exp_p.fast, res_ch.took_empty);
					errors++;
				end
				if (res_ch.out_priority !== exp_p.prio) begin
					$error("out_priority: expected %0h, got %0h", exp_p.prio,
						res_ch.out_priority);
					errors++;
				end
				if (res_ch.out_tag !== exp_p.tag) begin
					$error("out_tag: expected %0h, got %0h", exp_p.tag, res_ch.out_tag);
					errors++;
				end
			end
		end
	end

	// Watchdog: end the run if neither side completes a handshake for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
